FILE: rtl/astt_pkg.sv
package astt_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int ALARM_W  = 32;
    localparam int DELAY_W  = 16;
    localparam int WAITER_W = 8;
    localparam int SLICE_W  = 8;
    localparam int LEVEL_W  = 2;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = KIND_W;

    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ARM     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAKE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_KERNEL = 2'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARM,
        S_SCAN,
        S_SUM
    } t_state;

endpackage

FILE: rtl/alarm_slot_table_with_tick_unit.sv
// Alarm slot table with a 32-bit tick counter. An input transfer with tuser 0 arms an
// alarm in the lowest free slot and gives one answer; tuser 1 is a timer tick that gives
// one wake transfer per slot whose alarm equals the new count, in ascending slot order,
// followed by a summary transfer with tlast high. Alarm times live in a synchronous
// memory with a registered read, and per-slot occupancy flags cleared by reset mark the
// free slots, so no clearing pass follows reset. An arm request checks one occupancy flag
// per cycle. A tick reads one alarm memory entry per cycle while no wake waits to leave.
// Either request also waits in every cycle in which its answer, a wake or the summary
// waits for the previous result to leave on m_axis_tready. One item is worked on at a
// time.
module alarm_slot_table_with_tick_unit #(
    parameter int SLOTS = astt_pkg::SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: delay_ticks, waiter_id, slice_count, prev_level, zero fill.
    input  logic [astt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [astt_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: slot_index, woken_id, table_full, resched, new_slice, zero fill.
    output logic [astt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0: kind.
    output logic [astt_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    astt_pkg::t_state r_state;
    astt_pkg::t_state n_state;

    logic                              r_op;
    logic [astt_pkg::DELAY_W-1:0]      r_delay;
    logic [astt_pkg::WAITER_W-1:0]     r_waiter;
    logic [astt_pkg::SLICE_W-1:0]      r_slice;
    logic [astt_pkg::LEVEL_W-1:0]      r_level;
    logic [astt_pkg::ALARM_W-1:0]      r_tick;
    logic [SLOTS-1:0]                  r_busy;

    logic [astt_pkg::ALARM_W-1:0]      r_alarm_mem [SLOTS];
    logic [astt_pkg::WAITER_W-1:0]     r_waiter_mem [SLOTS];
    logic [astt_pkg::ALARM_W-1:0]      r_alarm_q;
    logic [astt_pkg::WAITER_W-1:0]     r_waiter_q;

    logic [CW-1:0]                     r_rd_idx;
    logic                              r_ev_vld;
    logic [SW-1:0]                     r_ev_idx;

    logic                              r_out_vld;
    logic [astt_pkg::KIND_W-1:0]       r_out_kind;
    logic [astt_pkg::SLOT_W-1:0]       r_out_slot;
    logic [astt_pkg::WAITER_W-1:0]     r_out_woken;
    logic                              r_out_full;
    logic                              r_out_resched;
    logic [astt_pkg::SLICE_W-1:0]      r_out_slice;
    logic                              r_out_last;

    logic                              s_acc;
    logic                              can_load;
    logic                              out_load;
    logic [astt_pkg::KIND_W-1:0]       n_out_kind;
    logic [astt_pkg::SLOT_W-1:0]       n_out_slot;
    logic [astt_pkg::WAITER_W-1:0]     n_out_woken;
    logic                              n_out_full;
    logic                              n_out_resched;
    logic [astt_pkg::SLICE_W-1:0]      n_out_slice;
    logic                              n_out_last;

    logic [SW-1:0]                     rd_addr;
    logic [SW+astt_pkg::SLOT_W-1:0]    arm_slot_ext;
    logic [SW+astt_pkg::SLOT_W-1:0]    ev_slot_ext;
    logic [astt_pkg::ALARM_W-1:0]      alarm_sum;
    logic                              alarm_we;
    logic                              arm_adv;
    logic                              rd_en;
    logic                              hit;
    logic                              stall;
    logic                              scan_done;
    logic                              busy_clr;

    assign s_acc        = s_axis_tvalid && s_axis_tready;
    assign can_load     = !r_out_vld || m_axis_tready;
    assign rd_addr      = r_rd_idx[SW-1:0];
    assign arm_slot_ext = {{astt_pkg::SLOT_W{1'b0}}, rd_addr};
    assign ev_slot_ext  = {{astt_pkg::SLOT_W{1'b0}}, r_ev_idx};
    assign alarm_sum    = r_tick + {{(astt_pkg::ALARM_W - astt_pkg::DELAY_W){1'b0}}, r_delay};

    assign hit       = (r_state == astt_pkg::S_SCAN) && r_ev_vld && r_busy[r_ev_idx]
                       && (r_alarm_q == r_tick);
    assign stall     = hit && !can_load;
    assign rd_en     = (r_state == astt_pkg::S_SCAN) && !stall && (r_rd_idx != CW'(SLOTS));
    assign scan_done = !stall && (r_rd_idx == CW'(SLOTS));

    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        n_out_kind    = astt_pkg::KIND_ARM;
        n_out_slot    = '0;
        n_out_woken   = '0;
        n_out_full    = 1'b0;
        n_out_resched = 1'b0;
        n_out_slice   = '0;
        n_out_last    = 1'b0;
        alarm_we      = 1'b0;
        arm_adv       = 1'b0;
        busy_clr      = 1'b0;
        unique case (r_state)
            astt_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            astt_pkg::S_ARM: begin
                if (!r_busy[rd_addr]) begin
                    if (can_load) begin
                        out_load   = 1'b1;
                        alarm_we   = 1'b1;
                        n_out_slot = arm_slot_ext[astt_pkg::SLOT_W-1:0];
                        n_out_last = 1'b1;
                    end
                end else if (r_rd_idx == CW'(SLOTS - 1)) begin
                    if (can_load) begin
                        out_load   = 1'b1;
                        n_out_full = 1'b1;
                        n_out_last = 1'b1;
                    end
                end else begin
                    arm_adv = 1'b1;
                end
            end
            astt_pkg::S_SCAN: begin
                if (hit && can_load) begin
                    out_load    = 1'b1;
                    busy_clr    = 1'b1;
                    n_out_kind  = astt_pkg::KIND_WAKE;
                    n_out_slot  = ev_slot_ext[astt_pkg::SLOT_W-1:0];
                    n_out_woken = r_waiter_q;
                end
            end
            astt_pkg::S_SUM: begin
                if (can_load) begin
                    out_load      = 1'b1;
                    n_out_kind    = astt_pkg::KIND_SUMMARY;
                    n_out_slice   = (r_slice == '0) ? '0 : r_slice - 1'b1;
                    n_out_resched = (r_slice <= astt_pkg::SLICE_W'(1))
                                    && (r_level != astt_pkg::LEVEL_KERNEL);
                    n_out_last    = 1'b1;
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            astt_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_state = (s_axis_tuser[0] == astt_pkg::OP_TICK) ? astt_pkg::S_SCAN
                                                                     : astt_pkg::S_ARM;
                end
            end
            astt_pkg::S_ARM: begin
                if (out_load) begin
                    n_state = astt_pkg::S_IDLE;
                end
            end
            astt_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = astt_pkg::S_SUM;
                end
            end
            astt_pkg::S_SUM: begin
                if (out_load) begin
                    n_state = astt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = astt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= astt_pkg::S_IDLE;
            r_tick   <= '0;
            r_busy   <= '0;
            r_rd_idx <= '0;
            r_ev_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_rd_idx <= '0;
                r_ev_vld <= 1'b0;
                if (s_axis_tuser[0] == astt_pkg::OP_TICK) begin
                    r_tick <= r_tick + 1'b1;
                end
            end
            if (arm_adv || rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if ((r_state == astt_pkg::S_SCAN) && !stall) begin
                r_ev_vld <= rd_en;
            end
            if (alarm_we) begin
                r_busy[rd_addr] <= (alarm_sum != '0);
            end
            if (busy_clr) begin
                r_busy[r_ev_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op     <= s_axis_tuser[0];
            r_delay  <= s_axis_tdata[15:0];
            r_waiter <= s_axis_tdata[23:16];
            r_slice  <= s_axis_tdata[31:24];
            r_level  <= s_axis_tdata[33:32];
        end
        if (rd_en) begin
            r_ev_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (alarm_we) begin
            r_alarm_mem[rd_addr]  <= alarm_sum;
            r_waiter_mem[rd_addr] <= r_waiter;
        end
        if (rd_en) begin
            r_alarm_q  <= r_alarm_mem[rd_addr];
            r_waiter_q <= r_waiter_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind    <= n_out_kind;
            r_out_slot    <= n_out_slot;
            r_out_woken   <= n_out_woken;
            r_out_full    <= n_out_full;
            r_out_resched <= n_out_resched;
            r_out_slice   <= n_out_slice;
            r_out_last    <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out_slice, r_out_resched, r_out_full,
                            r_out_woken, r_out_slot};

`ifndef ASSERT_OFF
    a_wake_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_kind == astt_pkg::KIND_WAKE)) |-> !r_out_last)
        else $error("Wake transfer marked as last.");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (s_axis_tuser[0] == astt_pkg::OP_TICK)) |=> (r_tick == $past(r_tick) + 1'b1))
        else $error("Tick count did not advance by one.");

    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alarm_we |-> (!r_busy[rd_addr] && (r_op == astt_pkg::OP_ARM)))
        else $error("Alarm written into an occupied slot.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == astt_pkg::S_SCAN) |-> (r_rd_idx <= CW'(SLOTS)))
        else $error("Scan index ran past the table.");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> can_load)
        else $error("Result loaded over an untaken result.");
`endif

endmodule
